@@ rtl/wbcs_pkg.sv @@
// shared types and constants for the white blob centroid steering block
// no dependencies; compiled first

package wbcs_pkg;

  localparam int unsigned CfgWidth   = 13;
  localparam int unsigned ColWidth   = 12;
  localparam int unsigned CountWidth = 23;
  localparam int unsigned SumWidth   = 34;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned CodeWidth  = 2;
  localparam int unsigned QuotBits   = 12;
  localparam int unsigned StepWidth  = 4;

  localparam logic [CfgWidth-1:0]   WidthReset = 13'd640;
  localparam logic [CfgWidth-1:0]   MaxWidth   = 13'd4096;
  localparam logic [CountWidth-1:0] MaxPixels  = 23'd4194304;
  localparam logic [ChanWidth-1:0]  WhiteLevel = 8'd255;

  typedef enum logic [CodeWidth-1:0] {
    STEER_STOP     = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_STRAIGHT = 2'd2,
    STEER_RIGHT    = 2'd3
  } steer_e;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_DONE
  } core_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_STEP
  } div_state_e;

endpackage

@@ rtl/wbcs_if.sv @@
// channel interfaces: pixel requests in, steering results out
// depends on wbcs_pkg for field widths

interface wbcs_pixel_if;
  logic                             valid;
  logic                             ready;
  logic [wbcs_pkg::ChanWidth-1:0]   red;
  logic [wbcs_pkg::ChanWidth-1:0]   green;
  logic [wbcs_pkg::ChanWidth-1:0]   blue;
  logic                             frame_end;

  modport source (output valid, red, green, blue, frame_end, input ready);
  modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

interface wbcs_result_if;
  logic                             valid;
  logic                             ready;
  logic [wbcs_pkg::CodeWidth-1:0]   steer_code;
  logic [wbcs_pkg::ColWidth-1:0]    centroid_column;
  logic [wbcs_pkg::CountWidth-1:0]  white_total;

  modport source (output valid, steer_code, centroid_column, white_total, input ready);
  modport sink   (input valid, steer_code, centroid_column, white_total, output ready);
endinterface

@@ rtl/wbcs_divider.sv @@
// iterative restoring divider: column sum over white count, clamped to 12 bits
// one shared subtractor, one quotient bit per cycle; depends on wbcs_pkg

module wbcs_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wbcs_pkg::SumWidth-1:0]     dividend_i,
  input  logic [wbcs_pkg::CountWidth-1:0]   divisor_i,
  output logic                              done_o,
  output logic [wbcs_pkg::ColWidth-1:0]     quot_o
);
  import wbcs_pkg::*;

  localparam int unsigned HiWidth = SumWidth - QuotBits;

  div_state_e              state_q, state_d;
  logic [HiWidth-1:0]      hi_q;
  logic [QuotBits-1:0]     lo_q, lo_d;
  logic [CountWidth-1:0]   den_q;
  logic [CountWidth-1:0]   rem_q, rem_d;
  logic [QuotBits-1:0]     quot_q, quot_d;
  logic [StepWidth-1:0]    step_q, step_d;
  logic                    done_q, done_d;

  // shared subtract unit
  logic [CountWidth:0]     sub_a;
  logic [CountWidth+1:0]   sub_diff;
  logic                    sub_ge;
  logic                    last_step;

  assign sub_diff  = {1'b0, sub_a} - {2'b0, den_q};
  assign sub_ge    = ~sub_diff[CountWidth+1];
  assign last_step = (step_q == StepWidth'(QuotBits - 1));

  always_comb begin
    unique case (state_q)
      DIV_IDLE:  state_d = start_i ? DIV_CHECK : DIV_IDLE;
      // quotient overflows 12 bits when the upper part alone reaches the divisor
      DIV_CHECK: state_d = sub_ge ? DIV_IDLE : DIV_STEP;
      DIV_STEP:  state_d = last_step ? DIV_IDLE : DIV_STEP;
      default:   state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    sub_a  = '0;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    step_d = step_q;
    done_d = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        step_d = '0;
      end
      DIV_CHECK: begin
        sub_a = (CountWidth+1)'(hi_q);
        rem_d = CountWidth'(hi_q);
        if (sub_ge) begin
          quot_d = '1;
          done_d = 1'b1;
        end
      end
      DIV_STEP: begin
        sub_a  = {rem_q, lo_q[QuotBits-1]};
        rem_d  = sub_ge ? sub_diff[CountWidth-1:0] : sub_a[CountWidth-1:0];
        lo_d   = {lo_q[QuotBits-2:0], 1'b0};
        quot_d = {quot_q[QuotBits-2:0], sub_ge};
        step_d = step_q + StepWidth'(1);
        done_d = last_step;
      end
      default: begin
        sub_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      hi_q   <= dividend_i[SumWidth-1:QuotBits];
      lo_q   <= dividend_i[QuotBits-1:0];
      den_q  <= divisor_i;
      quot_q <= '0;
      rem_q  <= '0;
    end else begin
      lo_q   <= lo_d;
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/white_blob_centroid_steer_core.sv @@
// top level of the white blob centroid steering block
// depends on wbcs_pkg, wbcs_if and wbcs_divider
//
// pixels arrive on pixel_i in raster order, one request per cycle while ready
// is high. a column counter wraps at the configured image width (cfg_we_i and
// cfg_wdata_i, to be written by the user only while no frame is in flight;
// the block does not enforce this. 0 acts as 1 and values above 4096 act
// as 4096). pure white pixels add their column to a running sum and one to
// a count, both saturating. the pixel flagged frame_end closes the frame:
// the accumulators clear at once and the mean is formed by the restoring
// divider, one overflow check plus one quotient bit per cycle. ready stays
// low while the divider runs (no division when no white pixel was seen;
// only the check when the mean overflows 12 bits) and until the result
// enters the output register, so no pixel is taken in that time.
// the result (steer code, mean column, white count) goes to result_o through
// an output register; if the receiver stalls, the block holds the finished
// result and keeps ready low until the register frees, so nothing is lost.
// pixels of the next frame are taken while an earlier result still waits.
// reset clears the accumulators and output valid and restores width 640.

module white_blob_centroid_steer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wbcs_pkg::CfgWidth-1:0]   cfg_wdata_i,
  wbcs_pixel_if.sink                      pixel_i,
  wbcs_result_if.source                   result_o
);
  import wbcs_pkg::*;

  core_state_e             state_q, state_d;
  logic [CfgWidth-1:0]     width_q;
  logic [CfgWidth-1:0]     width_eff;
  logic [CfgWidth-1:0]     frame_width_q;
  logic [ColWidth-1:0]     column_q, column_d;
  logic [CountWidth-1:0]   count_q, count_d;
  logic [SumWidth-1:0]     sum_q, sum_d;
  logic [CountWidth-1:0]   total_q;

  logic [ColWidth-1:0]     col_cur;
  logic [CfgWidth-1:0]     col_inc;
  logic [ColWidth-1:0]     col_next;
  logic                    white;
  logic [CountWidth-1:0]   count_upd;
  logic [SumWidth-1:0]     sum_upd;
  logic [SumWidth:0]       sum_add;

  logic                    accept;
  logic                    closing;
  logic                    div_start;
  logic                    div_done;
  logic [ColWidth-1:0]     div_quot;

  logic                    out_valid_q;
  logic [CodeWidth-1:0]    out_code_q;
  logic [ColWidth-1:0]     out_col_q;
  logic [CountWidth-1:0]   out_total_q;
  logic                    out_load;

  logic [ColWidth-1:0]     mean;
  logic [ColWidth+1:0]     mean3;
  steer_e                  code;

  always_comb begin
    if (width_q == '0) begin
      width_eff = CfgWidth'(1);
    end else if (width_q > MaxWidth) begin
      width_eff = MaxWidth;
    end else begin
      width_eff = width_q;
    end
  end

  // per-pixel accumulate
  assign col_cur  = ({1'b0, column_q} >= width_eff) ? '0 : column_q;
  assign col_inc  = {1'b0, col_cur} + CfgWidth'(1);
  assign col_next = (col_inc >= width_eff) ? '0 : col_inc[ColWidth-1:0];
  assign white    = (pixel_i.red == WhiteLevel) && (pixel_i.green == WhiteLevel) &&
                    (pixel_i.blue == WhiteLevel);
  assign sum_add  = {1'b0, sum_q} + (SumWidth+1)'(col_cur);

  always_comb begin
    count_upd = count_q;
    sum_upd   = sum_q;
    if (white && count_q < MaxPixels) begin
      count_upd = count_q + CountWidth'(1);
      sum_upd   = sum_add[SumWidth] ? '1 : sum_add[SumWidth-1:0];
    end
  end

  assign accept    = pixel_i.valid && pixel_i.ready;
  assign closing   = accept && pixel_i.frame_end;
  assign div_start = closing && (count_upd != '0);

  always_comb begin
    column_d = column_q;
    count_d  = count_q;
    sum_d    = sum_q;
    if (closing) begin
      column_d = '0;
      count_d  = '0;
      sum_d    = '0;
    end else if (accept) begin
      column_d = col_next;
      count_d  = count_upd;
      sum_d    = sum_upd;
    end
  end

  wbcs_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_upd),
    .divisor_i  (count_upd),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // steering decision: mean < w/3 iff 3*mean+3 <= w, mean > 2w/3 iff 3*mean > 2w
  assign mean  = (total_q == '0) ? '0 : div_quot;
  assign mean3 = {1'b0, mean, 1'b0} + (ColWidth+2)'(mean);

  always_comb begin
    if (total_q == '0) begin
      code = STEER_STOP;
    end else if ({1'b0, mean3} + (ColWidth+3)'(3) <= (ColWidth+3)'(frame_width_q)) begin
      code = STEER_LEFT;
    end else if (mean3 > {frame_width_q, 1'b0}) begin
      code = STEER_RIGHT;
    end else begin
      code = STEER_STRAIGHT;
    end
  end

  // next state
  always_comb begin
    unique case (state_q)
      ST_ACC: begin
        if (div_start) begin
          state_d = ST_DIV;
        end else if (closing) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_DIV:  state_d = div_done ? ST_DONE : ST_DIV;
      ST_DONE: state_d = (!out_valid_q || result_o.ready) ? ST_ACC : ST_DONE;
      default: state_d = ST_ACC;
    endcase
  end

  // state outputs
  always_comb begin
    pixel_i.ready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_ACC:  pixel_i.ready = 1'b1;
      ST_DIV:  pixel_i.ready = 1'b0;
      ST_DONE: out_load      = !out_valid_q || result_o.ready;
      default: pixel_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      width_q     <= WidthReset;
      column_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      column_q <= column_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (closing) begin
      total_q       <= count_upd;
      frame_width_q <= width_eff;
    end
    if (out_load) begin
      out_code_q  <= code;
      out_col_q   <= mean;
      out_total_q <= total_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.steer_code      = out_code_q;
  assign result_o.centroid_column = out_col_q;
  assign result_o.white_total     = out_total_q;

endmodule

@@ tb/tb_top.sv @@
// testbench for white_blob_centroid_steer_core: random and directed pixel frames
// depends on wbcs_pkg, wbcs_if and the block's rtl; checks each result against a local predictor

module tb_top;
  import wbcs_pkg::*;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
    logic                 frame_end;
  } pixel_t;

  typedef struct packed {
    steer_e                code;
    logic [ColWidth-1:0]   column;
    logic [CountWidth-1:0] total;
  } steer_result_t;

  localparam longint unsigned SumLimit = (64'd1 << SumWidth) - 1;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned HoldCycles = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgWidth-1:0] cfg_wdata;

  wbcs_pixel_if  pix ();
  wbcs_result_if res ();

  white_blob_centroid_steer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pixel_i     (pix),
    .result_o    (res)
  );

  pixel_t        pixel_backlog[$];
  steer_result_t steer_expected[$];
  pixel_t        drv_pixel;
  steer_result_t seen_result;
  steer_result_t want_result;
  int            err_cnt = 0;
  int            tx_idle_pct;
  int            rx_stall_pct;
  logic          rx_hold;
  logic          hold_go;
  logic          hold_done;

  // predictor state
  logic [CfgWidth-1:0] width_model;
  longint unsigned     col_pos = 0;
  longint unsigned     white_cnt = 0;
  longint unsigned     col_sum = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int width_in_use(logic [CfgWidth-1:0] w);
    int r;
    r = int'(w);
    if (r == 0) r = 1;
    if (r > int'(MaxWidth)) r = int'(MaxWidth);
    return r;
  endfunction

  // advances the centroid accumulators by one pixel; returns 1 when a result is due
  function automatic bit predict_steer(pixel_t p, output steer_result_t r);
    longint unsigned w;
    longint unsigned col;
    longint unsigned mean;
    w = longint'(width_in_use(width_model));
    col = col_pos;
    r = '0;
    if (col >= w) col = 0;
    if (p.red == WhiteLevel && p.green == WhiteLevel && p.blue == WhiteLevel &&
        white_cnt < longint'(MaxPixels)) begin
      white_cnt++;
      if (col_sum > SumLimit - col) col_sum = SumLimit;
      else col_sum += col;
    end
    col_pos = (col + 1 >= w) ? 0 : col + 1;
    if (!p.frame_end) return 1'b0;
    mean = 0;
    if (white_cnt == 0) begin
      r.code = STEER_STOP;
    end else begin
      mean = col_sum / white_cnt;
      if (mean > 4095) mean = 4095;
      if (mean < w / 3) r.code = STEER_LEFT;
      else if (mean > (w * 2) / 3) r.code = STEER_RIGHT;
      else r.code = STEER_STRAIGHT;
    end
    r.column = mean[ColWidth-1:0];
    r.total = white_cnt[CountWidth-1:0];
    col_pos = 0;
    white_cnt = 0;
    col_sum = 0;
    return 1'b1;
  endfunction

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid     <= 1'b0;
      pix.red       <= '0;
      pix.green     <= '0;
      pix.blue      <= '0;
      pix.frame_end <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        drv_pixel = pixel_backlog.pop_front();
        pix.valid     <= 1'b1;
        pix.red       <= drv_pixel.red;
        pix.green     <= drv_pixel.green;
        pix.blue      <= drv_pixel.blue;
        pix.frame_end <= drv_pixel.frame_end;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // receiver hold-off, counted here while the main sequence keeps sending
  initial begin
    rx_hold   = 1'b0;
    hold_done = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold   <= 1'b0;
    hold_done = 1'b1;
  end

  // monitor: predict on accepted pixel requests, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        if (steer_expected.size() == 0) begin
          $error("result with no expectation: steer_code %0d centroid_column %0d white_total %0d",
                 res.steer_code, res.centroid_column, res.white_total);
          err_cnt++;
        end else begin
          want_result = steer_expected.pop_front();
          if (res.steer_code !== want_result.code) begin
            $error("steer_code expected %0d actual %0d", want_result.code, res.steer_code);
            err_cnt++;
          end
          if (res.centroid_column !== want_result.column) begin
            $error("centroid_column expected %0d actual %0d",
                   want_result.column, res.centroid_column);
            err_cnt++;
          end
          if (res.white_total !== want_result.total) begin
            $error("white_total expected %0d actual %0d", want_result.total, res.white_total);
            err_cnt++;
          end
        end
      end
      if (pix.valid && pix.ready) begin
        if (predict_steer({pix.red, pix.green, pix.blue, pix.frame_end}, seen_result))
          steer_expected.push_back(seen_result);
      end
    end
  end

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.frame_end = fe;
    pixel_backlog.push_back(p);
  endtask

  // whites go in columns lo..hi with chance pct; other pixels have each channel white or random
  task automatic queue_frame(int len, int lo, int hi, int pct);
    int w;
    int col;
    pixel_t p;
    w = width_in_use(width_model);
    for (int i = 0; i < len; i++) begin
      col = i % w;
      if (col >= lo && col <= hi && $urandom_range(99) < pct) begin
        p.red = WhiteLevel;
        p.green = WhiteLevel;
        p.blue = WhiteLevel;
      end else begin
        p.red   = $urandom_range(1) ? WhiteLevel : 8'($urandom_range(255));
        p.green = $urandom_range(1) ? WhiteLevel : 8'($urandom_range(255));
        p.blue  = $urandom_range(1) ? WhiteLevel : 8'($urandom_range(255));
      end
      p.frame_end = (i == len - 1);
      pixel_backlog.push_back(p);
    end
  endtask

  task automatic write_width(logic [CfgWidth-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    width_model = v;
  endtask

  // wait until every request is taken and every result is back, then wait out the settle period
  task automatic settle();
    while (pixel_backlog.size() != 0 || pix.valid || steer_expected.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CfgWidth-1:0] w);
    int items;
    int len;
    int lo;
    int hi;
    int pct;
    int weff;
    write_width(w);
    weff = width_in_use(w);
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct <= 53; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct <= 0;  rx_stall_pct <= 53; end
        default: begin tx_idle_pct <= 25; rx_stall_pct <= 25; end
      endcase
      items = 0;
      while (items < 8) begin
        len = $urandom_range(1, (3 * weff < 40) ? 3 * weff : 40);
        lo = $urandom_range(weff - 1);
        hi = $urandom_range(weff - 1, lo);
        pct = ($urandom_range(9) == 0) ? 0 : $urandom_range(100, 20);
        queue_frame(len, lo, hi, pct);
        items += len;
      end
      while (pixel_backlog.size() != 0) @(posedge clk_i);
    end
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    hold_go       = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    width_model   = WidthReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset width, no white, lone white, near-white misses
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd254, 1'b0);
    push_pixel(8'd254, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd254, 8'd255, 1'b1);
    settle();
    // directed: width 6, right then straight then a frame that wraps a row
    write_width(13'd6);
    for (int i = 0; i < 6; i++)
      push_pixel(i == 5 ? 8'd255 : 8'd0, 8'd255, 8'd255, i == 5);
    for (int i = 0; i < 6; i++)
      push_pixel(8'd255, (i == 2 || i == 3) ? 8'd255 : 8'd128, 8'd255, i == 5);
    for (int i = 0; i < 8; i++)
      push_pixel(8'd255, 8'd255, i >= 6 ? 8'd255 : 8'd0, i == 7);
    settle();

    run_phase(13'd3);
    run_phase(13'd1);
    run_phase(13'd0);
    run_phase(13'd6);
    run_phase(13'd17);
    run_phase(13'd640);
    run_phase(13'd8191);
    run_phase(13'd2);
    run_phase(13'($urandom_range(64, 1)));
    run_phase(13'($urandom_range(8191)));
    run_phase(13'd4096);
    // one long frame at width 640 so the middle third is reached
    write_width(13'd640);
    queue_frame(260, 220, 259, 50);
    settle();

    // long receiver hold-off while short frames keep coming
    write_width(13'd3);
    tx_idle_pct  <= 0;
    rx_stall_pct <= 0;
    for (int i = 0; i < 60; i++) queue_frame(3, 0, 2, 60);
    hold_go = 1'b1;
    wait (hold_done === 1'b1);
    settle();

    if (err_cnt == 0 && steer_expected.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
